// ===== src/nrmc_pkg.sv =====
package nrmc_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] FLD_STATUS = 3'd2;
  localparam logic [2:0] FLD_LAT    = 3'd3;
  localparam logic [2:0] FLD_NS     = 3'd4;
  localparam logic [2:0] FLD_LON    = 3'd5;
  localparam logic [2:0] FLD_EW     = 3'd6;
  localparam logic [2:0] FLD_DONE   = 3'd7;

  localparam logic [2:0] MIN_DIGITS = 3'd7;
  localparam logic [3:0] POS_MAX    = 4'd15;
  localparam logic [3:0] LAT_DEG_DIGITS = 4'd2;
  localparam logic [3:0] LON_DEG_DIGITS = 4'd3;

  localparam logic [23:0] DEG_SCALE = 24'd10000000;
  localparam logic [31:0] RECIP3    = 32'd2863311531;
  localparam int          RECIP3_SH = 33;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_NO_COMMA = 2'd1,
    ERR_SHORT    = 2'd2
  } err_t;

  typedef struct packed {
    logic        fix;
    logic [6:0]  lat_deg;
    logic [23:0] lat_min;
    logic [2:0]  lat_cnt;
    logic [9:0]  lon_deg;
    logic [23:0] lon_min;
    logic [2:0]  lon_cnt;
    logic [7:0]  ns;
    logic [7:0]  ew;
    err_t        err;
  } snap_t;

  typedef struct packed {
    logic       fix;
    logic [7:0] ns;
    logic [7:0] ew;
    err_t       err;
  } side_t;

  // pads the minute digits out to the mm.mmmmm form
  function automatic logic [23:0] pad_scale(input logic [2:0] cnt);
    logic [23:0] s;
    begin
      case (cnt)
        3'd0: s = 24'd10000000;
        3'd1: s = 24'd1000000;
        3'd2: s = 24'd100000;
        3'd3: s = 24'd10000;
        3'd4: s = 24'd1000;
        3'd5: s = 24'd100;
        3'd6: s = 24'd10;
        default: s = 24'd1;
      endcase
      return s;
    end
  endfunction

endpackage

// ===== src/nrmc_parser.sv =====
module nrmc_parser
  import nrmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_end_of_sentence,
  input  logic       nxt_ready,
  output logic       snap_valid,
  output snap_t      snap
);

  logic [2:0]  fn_r, fn_nxt, tb_fn;
  logic [3:0]  cp_r, cp_nxt, tb_cp;
  logic [6:0]  lat_deg_r, lat_deg_nxt, tb_lat_deg;
  logic [23:0] lat_min_r, lat_min_nxt, tb_lat_min;
  logic [2:0]  lat_cnt_r, lat_cnt_nxt, tb_lat_cnt;
  logic [9:0]  lon_deg_r, lon_deg_nxt, tb_lon_deg;
  logic [23:0] lon_min_r, lon_min_nxt, tb_lon_min;
  logic [2:0]  lon_cnt_r, lon_cnt_nxt, tb_lon_cnt;
  logic [7:0]  ns_r, ns_nxt, tb_ns;
  logic [7:0]  ew_r, ew_nxt, tb_ew;
  logic        fix_r, fix_nxt, tb_fix;
  logic        snap_valid_r, snap_valid_nxt;
  snap_t       snap_r, snap_nxt;

  logic        adv, acc, is_digit, bump, keep;
  logic [3:0]  dv;
  err_t        err;

  assign adv      = !snap_valid_r || nxt_ready;
  assign in_ready = adv;
  assign acc      = in_valid && adv;
  assign is_digit = (in_rx_byte >= CH_ZERO) && (in_rx_byte <= CH_NINE);
  assign dv       = in_rx_byte[3:0];

  // one byte of the sentence
  always_comb begin
    tb_fn      = fn_r;
    tb_cp      = cp_r;
    tb_lat_deg = lat_deg_r;
    tb_lat_min = lat_min_r;
    tb_lat_cnt = lat_cnt_r;
    tb_lon_deg = lon_deg_r;
    tb_lon_min = lon_min_r;
    tb_lon_cnt = lon_cnt_r;
    tb_ns      = ns_r;
    tb_ew      = ew_r;
    tb_fix     = fix_r;
    bump       = 1'b0;
    if (fn_r != FLD_DONE) begin
      if (in_rx_byte == CH_COMMA) begin
        tb_fn = fn_r + 3'd1;
        tb_cp = '0;
      end else begin
        bump = 1'b1;
        case (fn_r)
          FLD_STATUS: begin
            if (cp_r == '0) begin
              if (in_rx_byte == CH_A) begin
                tb_fix = 1'b1;
              end else if (in_rx_byte == CH_V) begin
                tb_fix = 1'b0;
              end
            end
          end
          FLD_LAT: begin
            if (!is_digit) begin
              bump = 1'b0;
            end else if (cp_r < LAT_DEG_DIGITS) begin
              tb_lat_deg = lat_deg_r * 7'd10 + {3'b000, dv};
            end else if (lat_cnt_r < MIN_DIGITS) begin
              tb_lat_min = lat_min_r * 24'd10 + {20'd0, dv};
              tb_lat_cnt = lat_cnt_r + 3'd1;
            end
          end
          FLD_NS: begin
            if (cp_r == '0) begin
              tb_ns = in_rx_byte;
            end
          end
          FLD_LON: begin
            if (!is_digit) begin
              bump = 1'b0;
            end else if (cp_r < LON_DEG_DIGITS) begin
              tb_lon_deg = lon_deg_r * 10'd10 + {6'd0, dv};
            end else if (lon_cnt_r < MIN_DIGITS) begin
              tb_lon_min = lon_min_r * 24'd10 + {20'd0, dv};
              tb_lon_cnt = lon_cnt_r + 3'd1;
            end
          end
          FLD_EW: begin
            if (cp_r == '0) begin
              tb_ew = in_rx_byte;
            end
          end
          default: begin
          end
        endcase
        if (bump && (cp_r != POS_MAX)) begin
          tb_cp = cp_r + 4'd1;
        end
      end
    end
  end

  always_comb begin
    if (tb_fn == '0) begin
      err = ERR_NO_COMMA;
    end else if (tb_fn != FLD_DONE) begin
      err = ERR_SHORT;
    end else begin
      err = ERR_NONE;
    end
    keep = tb_fix && (err == ERR_NONE);
  end

  always_comb begin
    fn_nxt      = fn_r;
    cp_nxt      = cp_r;
    lat_deg_nxt = lat_deg_r;
    lat_min_nxt = lat_min_r;
    lat_cnt_nxt = lat_cnt_r;
    lon_deg_nxt = lon_deg_r;
    lon_min_nxt = lon_min_r;
    lon_cnt_nxt = lon_cnt_r;
    ns_nxt      = ns_r;
    ew_nxt      = ew_r;
    fix_nxt     = fix_r;
    if (acc) begin
      fix_nxt = tb_fix;
      if (in_end_of_sentence) begin
        fn_nxt      = '0;
        cp_nxt      = '0;
        lat_deg_nxt = '0;
        lat_min_nxt = '0;
        lat_cnt_nxt = '0;
        lon_deg_nxt = '0;
        lon_min_nxt = '0;
        lon_cnt_nxt = '0;
        ns_nxt      = '0;
        ew_nxt      = '0;
      end else begin
        fn_nxt      = tb_fn;
        cp_nxt      = tb_cp;
        lat_deg_nxt = tb_lat_deg;
        lat_min_nxt = tb_lat_min;
        lat_cnt_nxt = tb_lat_cnt;
        lon_deg_nxt = tb_lon_deg;
        lon_min_nxt = tb_lon_min;
        lon_cnt_nxt = tb_lon_cnt;
        ns_nxt      = tb_ns;
        ew_nxt      = tb_ew;
      end
    end
  end

  // coordinates forced to zero without a fix or on error
  always_comb begin
    snap_valid_nxt = snap_valid_r;
    snap_nxt       = snap_r;
    if (adv) begin
      snap_valid_nxt = acc && in_end_of_sentence;
    end
    if (acc && in_end_of_sentence) begin
      snap_nxt.fix     = tb_fix;
      snap_nxt.lat_deg = keep ? tb_lat_deg : '0;
      snap_nxt.lat_min = keep ? tb_lat_min : '0;
      snap_nxt.lat_cnt = tb_lat_cnt;
      snap_nxt.lon_deg = keep ? tb_lon_deg : '0;
      snap_nxt.lon_min = keep ? tb_lon_min : '0;
      snap_nxt.lon_cnt = tb_lon_cnt;
      snap_nxt.ns      = (err == ERR_NONE) ? tb_ns : '0;
      snap_nxt.ew      = (err == ERR_NONE) ? tb_ew : '0;
      snap_nxt.err     = err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fn_r         <= '0;
      cp_r         <= '0;
      lat_deg_r    <= '0;
      lat_min_r    <= '0;
      lat_cnt_r    <= '0;
      lon_deg_r    <= '0;
      lon_min_r    <= '0;
      lon_cnt_r    <= '0;
      ns_r         <= '0;
      ew_r         <= '0;
      fix_r        <= 1'b0;
      snap_valid_r <= 1'b0;
    end else begin
      fn_r         <= fn_nxt;
      cp_r         <= cp_nxt;
      lat_deg_r    <= lat_deg_nxt;
      lat_min_r    <= lat_min_nxt;
      lat_cnt_r    <= lat_cnt_nxt;
      lon_deg_r    <= lon_deg_nxt;
      lon_min_r    <= lon_min_nxt;
      lon_cnt_r    <= lon_cnt_nxt;
      ns_r         <= ns_nxt;
      ew_r         <= ew_nxt;
      fix_r        <= fix_nxt;
      snap_valid_r <= snap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

// ===== src/nrmc_coord.sv =====
module nrmc_coord
  import nrmc_pkg::*;
#(
  parameter int DEG_W = 7,
  parameter int OUT_W = 30
) (
  input  logic             clk,
  input  logic             ld1,
  input  logic             ld2,
  input  logic [DEG_W-1:0] deg,
  input  logic [23:0]      minutes,
  input  logic [2:0]       cnt,
  output logic [OUT_W-1:0] e7
);

  logic [DEG_W+23:0] deg_prod;
  logic [47:0]       sc_prod;
  logic [25:0]       x5;
  logic [57:0]       q_prod;

  logic [OUT_W-1:0]  deg1_r, deg1_nxt, deg2_r, deg2_nxt;
  logic [23:0]       scaled_r, scaled_nxt;
  logic [24:0]       q_r, q_nxt;

  // stage 1: degrees times 1e7, minutes padded to seven digits
  assign deg_prod = deg * DEG_SCALE;
  assign sc_prod  = minutes * pad_scale(cnt);

  // stage 2: times 5/3 via reciprocal of three
  assign x5     = {2'b00, scaled_r} + {scaled_r, 2'b00};
  assign q_prod = x5 * RECIP3;

  always_comb begin
    deg1_nxt   = ld1 ? deg_prod[OUT_W-1:0] : deg1_r;
    scaled_nxt = ld1 ? sc_prod[23:0] : scaled_r;
    deg2_nxt   = ld2 ? deg1_r : deg2_r;
    q_nxt      = ld2 ? q_prod[RECIP3_SH+24:RECIP3_SH] : q_r;
  end

  always_ff @(posedge clk) begin
    deg1_r   <= deg1_nxt;
    scaled_r <= scaled_nxt;
    deg2_r   <= deg2_nxt;
    q_r      <= q_nxt;
  end

  assign e7 = deg2_r + {{(OUT_W-25){1'b0}}, q_r};

endmodule

// ===== src/nmea_rmc_position_parser.sv =====
// nmea_rmc_position_parser
// input channel: one ascii character per word on in_rx_byte, with
// in_end_of_sentence high on the last character of an rmc sentence.
// the parser takes one word per cycle while in_ready is high; characters that are not the last
// one never produce a result word.
// result channel: one word per sentence with the fix flag, latitude and
// longitude in 1e-7 degree, the raw hemisphere characters and an error
// code (no comma, or ended before the e/w field closed).
// path: after the last character is accepted, the result moves through the
// parser's snapshot register, the multiply stages (degree scaling and
// minute padding, then the times 5/3 reciprocal multiply), then the
// output register.
// throughput: one word per cycle on both channels unless a stall holds
// them; the parser updates its sentence state for each byte.
// stall: when out_ready is low the result holds in the output register;
// the pipeline keeps accepting characters until the parser's snapshot
// register and all stages up to the output hold a sentence, then in_ready drops.
// reset: synchronous active-low rst_n clears the sentence state, the fix
// flag and all valid flags; no result is pending afterwards.
module nmea_rmc_position_parser
  import nrmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_end_of_sentence,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_fix_valid,
  output logic [29:0] out_latitude_e7,
  output logic [7:0]  out_lat_hemisphere,
  output logic [33:0] out_longitude_e7,
  output logic [7:0]  out_lon_hemisphere,
  output logic [1:0]  out_parse_error
);

  logic        snap_valid;
  snap_t       snap;
  logic        r2, r3, r4;
  logic        v2_r, v2_nxt, v3_r, v3_nxt, out_valid_r, out_valid_nxt;
  side_t       side2_r, side2_nxt, side3_r, side3_nxt, side_out_r, side_out_nxt;
  logic [29:0] lat_e7, lat_out_r, lat_out_nxt;
  logic [33:0] lon_e7, lon_out_r, lon_out_nxt;

  assign r4 = !out_valid_r || out_ready;
  assign r3 = !v3_r || r4;
  assign r2 = !v2_r || r3;

  nrmc_parser u_parser (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .in_end_of_sentence (in_end_of_sentence),
    .nxt_ready          (r2),
    .snap_valid         (snap_valid),
    .snap               (snap)
  );

  nrmc_coord #(.DEG_W(7), .OUT_W(30)) u_lat (
    .clk     (clk),
    .ld1     (r2 && snap_valid),
    .ld2     (r3 && v2_r),
    .deg     (snap.lat_deg),
    .minutes (snap.lat_min),
    .cnt     (snap.lat_cnt),
    .e7      (lat_e7)
  );

  nrmc_coord #(.DEG_W(10), .OUT_W(34)) u_lon (
    .clk     (clk),
    .ld1     (r2 && snap_valid),
    .ld2     (r3 && v2_r),
    .deg     (snap.lon_deg),
    .minutes (snap.lon_min),
    .cnt     (snap.lon_cnt),
    .e7      (lon_e7)
  );

  always_comb begin
    v2_nxt        = r2 ? snap_valid : v2_r;
    v3_nxt        = r3 ? v2_r : v3_r;
    out_valid_nxt = r4 ? v3_r : out_valid_r;
    side2_nxt     = side2_r;
    side3_nxt     = side3_r;
    side_out_nxt  = side_out_r;
    lat_out_nxt   = lat_out_r;
    lon_out_nxt   = lon_out_r;
    if (r2 && snap_valid) begin
      side2_nxt.fix = snap.fix;
      side2_nxt.ns  = snap.ns;
      side2_nxt.ew  = snap.ew;
      side2_nxt.err = snap.err;
    end
    if (r3 && v2_r) begin
      side3_nxt = side2_r;
    end
    if (r4 && v3_r) begin
      side_out_nxt = side3_r;
      lat_out_nxt  = lat_e7;
      lon_out_nxt  = lon_e7;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side2_r    <= side2_nxt;
    side3_r    <= side3_nxt;
    side_out_r <= side_out_nxt;
    lat_out_r  <= lat_out_nxt;
    lon_out_r  <= lon_out_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_fix_valid      = side_out_r.fix;
  assign out_latitude_e7    = lat_out_r;
  assign out_lat_hemisphere = side_out_r.ns;
  assign out_longitude_e7   = lon_out_r;
  assign out_lon_hemisphere = side_out_r.ew;
  assign out_parse_error    = side_out_r.err;

  a_end_byte_snapped: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_sentence |=> snap_valid)
    else $error("accepted last character did not reach the snapshot stage");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> snap_valid && v2_r && v3_r && out_valid_r && !out_ready)
    else $error("input stalled with a free pipeline stage");

  a_no_fix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fix_valid |-> out_latitude_e7 == '0 && out_longitude_e7 == '0)
    else $error("coordinates nonzero without a fix");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parse_error != ERR_NONE |->
      out_latitude_e7 == '0 && out_longitude_e7 == '0 &&
      out_lat_hemisphere == '0 && out_lon_hemisphere == '0)
    else $error("fields nonzero on a parse error");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !out_valid_r |=> out_valid_r)
    else $error("finished word did not move to the output register");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import nrmc_pkg::*;

  localparam int DIR_ITEMS    = 31;
  localparam int PHASE_ITEMS  = 380;
  localparam int PHASE_SENTS  = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic        fix;
    logic [29:0] lat;
    logic [7:0]  ns;
    logic [33:0] lon;
    logic [7:0]  ew;
    err_t        err;
  } fix_report_t;

  typedef struct {
    logic [7:0]  ch;
    logic        eos;
    logic        typed;
    fix_report_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        in_end_of_sentence;
  logic        out_valid;
  logic        out_ready;
  logic        out_fix_valid;
  logic [29:0] out_latitude_e7;
  logic [7:0]  out_lat_hemisphere;
  logic [33:0] out_longitude_e7;
  logic [7:0]  out_lon_hemisphere;
  logic [1:0]  out_parse_error;

  // side band that travels with the word on the input channel
  logic        row_typed;
  fix_report_t row_want;

  fix_report_t pending_reports[$];
  int          errors;
  int          sent_items;
  int          sentences;
  int          in_idle_pct;
  int          out_idle_pct;
  int          quiet_cycles;
  bit          hold_off_req;

  // sentence state mirrored from the parser
  logic [2:0]  s_field;
  logic [3:0]  s_pos;
  logic [6:0]  s_lat_deg;
  logic [23:0] s_lat_min;
  logic [2:0]  s_lat_cnt;
  logic [9:0]  s_lon_deg;
  logic [23:0] s_lon_min;
  logic [2:0]  s_lon_cnt;
  logic [7:0]  s_ns;
  logic [7:0]  s_ew;
  logic        s_fix;

  nmea_rmc_position_parser dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .in_end_of_sentence (in_end_of_sentence),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_fix_valid      (out_fix_valid),
    .out_latitude_e7    (out_latitude_e7),
    .out_lat_hemisphere (out_lat_hemisphere),
    .out_longitude_e7   (out_longitude_e7),
    .out_lon_hemisphere (out_lon_hemisphere),
    .out_parse_error    (out_parse_error)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] degrees_e7(input logic [63:0] deg, input logic [23:0] mins,
                                             input logic [2:0] cnt);
    logic [63:0] scale;
    logic [63:0] m;
    scale = 64'd1;
    for (int i = cnt; i < 7; i++) scale = scale * 64'd10;
    m = mins * scale;
    return deg * 64'd10000000 + (m * 64'd5) / 64'd3;
  endfunction

  task automatic clear_sentence();
    s_field   = '0;
    s_pos     = '0;
    s_lat_deg = '0;
    s_lat_min = '0;
    s_lat_cnt = '0;
    s_lon_deg = '0;
    s_lon_min = '0;
    s_lon_cnt = '0;
    s_ns      = '0;
    s_ew      = '0;
  endtask

  task automatic scan_char(input logic [7:0] c);
    logic       is_digit;
    logic [3:0] d;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d = 4'(c - CH_ZERO);
    if (s_field >= FLD_DONE) return;
    if (c == CH_COMMA) begin
      s_field = s_field + 3'd1;
      s_pos = '0;
      return;
    end
    case (s_field)
      FLD_STATUS: begin
        if (s_pos == 0) begin
          if (c == CH_A) s_fix = 1'b1;
          else if (c == CH_V) s_fix = 1'b0;
        end
      end
      FLD_LAT: begin
        if (!is_digit) return;
        if (s_pos < LAT_DEG_DIGITS) begin
          s_lat_deg = 7'(s_lat_deg * 10 + d);
        end else if (s_lat_cnt < MIN_DIGITS) begin
          s_lat_min = 24'(s_lat_min * 10 + d);
          s_lat_cnt = s_lat_cnt + 3'd1;
        end
      end
      FLD_NS: begin
        if (s_pos == 0) s_ns = c;
      end
      FLD_LON: begin
        if (!is_digit) return;
        if (s_pos < LON_DEG_DIGITS) begin
          s_lon_deg = 10'(s_lon_deg * 10 + d);
        end else if (s_lon_cnt < MIN_DIGITS) begin
          s_lon_min = 24'(s_lon_min * 10 + d);
          s_lon_cnt = s_lon_cnt + 3'd1;
        end
      end
      FLD_EW: begin
        if (s_pos == 0) s_ew = c;
      end
      default: ;
    endcase
    if (s_pos < POS_MAX) s_pos = s_pos + 4'd1;
  endtask

  task automatic close_sentence(output fix_report_t r);
    logic [63:0] v;
    r = '0;
    r.fix = s_fix;
    if (s_field == 0) r.err = ERR_NO_COMMA;
    else if (s_field < FLD_DONE) r.err = ERR_SHORT;
    else r.err = ERR_NONE;
    if (r.err == ERR_NONE) begin
      r.ns = s_ns;
      r.ew = s_ew;
      if (s_fix) begin
        v = degrees_e7(64'(s_lat_deg), s_lat_min, s_lat_cnt);
        r.lat = v[29:0];
        v = degrees_e7(64'(s_lon_deg), s_lon_min, s_lon_cnt);
        r.lon = v[33:0];
      end
    end
    clear_sentence();
  endtask

  // input side: update the mirrored state on every accepted word
  always @(posedge clk) begin : in_side
    fix_report_t r;
    if (!rst_n) begin
      clear_sentence();
      s_fix = 1'b0;
    end else if (in_valid && in_ready) begin
      scan_char(in_rx_byte);
      if (in_end_of_sentence) begin
        close_sentence(r);
        pending_reports.push_back(row_typed ? row_want : r);
      end
    end
  end

  always @(posedge clk) begin : out_side
    fix_report_t got;
    fix_report_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_fix_valid, out_latitude_e7, out_lat_hemisphere, out_longitude_e7,
              out_lon_hemisphere, err_t'(out_parse_error)};
      if (pending_reports.size() == 0) begin
        $display("%0t: result word with nothing expected: %0d/%0d/%h/%0d/%h/%0d", $time,
                 got.fix, got.lat, got.ns, got.lon, got.ew, got.err);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch fix/lat/ns/lon/ew/err exp %0d/%0d/%h/%0d/%h/%0d got %0d/%0d/%h/%0d/%h/%0d",
                   $time, want.fix, want.lat, want.ns, want.lon, want.ew, want.err,
                   got.fix, got.lat, got.ns, got.lon, got.ew, got.err);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic eos, input logic typed,
                           input fix_report_t want);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      in_rx_byte <= 8'($urandom_range(255));
      in_end_of_sentence <= 1'($urandom_range(1));
      row_typed <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= c;
    in_end_of_sentence <= eos;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_sentence(ref logic [7:0] text[$]);
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1, 1'b0, '0);
    sentences++;
  endtask

  function automatic logic [7:0] stray_char(input bit digits_ok);
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CH_COMMA || (!digits_ok && c >= CH_ZERO && c <= CH_NINE));
    return c;
  endfunction

  task automatic push_text(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endtask

  task automatic coord_text(ref logic [7:0] q[$], input int deg_digits);
    int ndig;
    bit nines;
    if ($urandom_range(19) == 0) return;
    nines = ($urandom_range(9) == 0);
    if ($urandom_range(4) == 0) ndig = $urandom_range(deg_digits + 10);
    else ndig = deg_digits + 2 + $urandom_range(6);
    for (int i = 0; i < ndig; i++) begin
      if (i == deg_digits + 2) q.push_back(".");
      q.push_back(nines ? CH_NINE : 8'(CH_ZERO + $urandom_range(9)));
      if ($urandom_range(29) == 0) q.push_back(stray_char(1'b0));
    end
  endtask

  task automatic letter_field(ref logic [7:0] q[$], input logic [7:0] a, input logic [7:0] b);
    int r;
    r = $urandom_range(9);
    if (r < 8) q.push_back(r[0] ? b : a);
    else if (r == 9) q.push_back(stray_char(1'b1));
    if ($urandom_range(9) == 0) q.push_back(stray_char(1'b1));
  endtask

  task automatic build_sentence(ref logic [7:0] q[$]);
    int n;
    q.delete();
    if ($urandom_range(3) == 0) repeat ($urandom_range(6)) q.push_back(stray_char(1'b1));
    else push_text(q, "$GPRMC");
    q.push_back(CH_COMMA);
    n = $urandom_range(10);
    repeat (n) q.push_back($urandom_range(5) == 0 ? "." : 8'(CH_ZERO + $urandom_range(9)));
    q.push_back(CH_COMMA);
    letter_field(q, CH_A, $urandom_range(2) == 0 ? CH_V : CH_A);
    q.push_back(CH_COMMA);
    coord_text(q, 2);
    q.push_back(CH_COMMA);
    letter_field(q, "N", "S");
    q.push_back(CH_COMMA);
    coord_text(q, 3);
    q.push_back(CH_COMMA);
    letter_field(q, "E", "W");
    q.push_back(CH_COMMA);
    repeat ($urandom_range(12)) q.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_text(ref dir_row_t rows[$], input string s, input fix_report_t want);
    for (int i = 0; i < s.len(); i++)
      rows.push_back('{s[i], i == s.len() - 1, i == s.len() - 1, want});
  endtask

  initial begin
    dir_row_t    rows[$];
    logic [7:0]  text[$];
    int          kind;
    int          cut;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rx_byte <= '0;
    in_end_of_sentence <= 1'b0;
    row_typed <= 1'b0;
    row_want <= '0;
    errors = 0;
    sent_items = 0;
    sentences = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_off_req = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // no comma at all, top byte value
    rows.push_back('{8'hFF, 1'b1, 1'b1, '{1'b0, 30'd0, 8'd0, 34'd0, 8'd0, ERR_NO_COMMA}});
    // largest coordinates, empty hemispheres, end mark on the last comma
    add_text(rows, ",,A,999999999,,9999999999,,",
             '{1'b1, 30'd1006666665, 8'd0, 34'd10006666665, 8'd0, ERR_NONE});
    // status clears the fix even though the sentence is short
    add_text(rows, ",,V", '{1'b0, 30'd0, 8'd0, 34'd0, 8'd0, ERR_SHORT});
    foreach (rows[i]) send_char(rows[i].ch, rows[i].eos, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          in_idle_pct = 15;
          out_idle_pct = 78;
        end
        1: begin
          in_idle_pct = 78;
          out_idle_pct = 15;
        end
        default: begin
          in_idle_pct = 0;
          out_idle_pct = 0;
          hold_off_req = 1'b1;
        end
      endcase
      while (sent_items < DIR_ITEMS + (ph + 1) * PHASE_ITEMS || sentences < (ph + 1) * PHASE_SENTS)
      begin
        kind = $urandom_range(99);
        build_sentence(text);
        if (kind >= 88) begin
          text.delete();
          repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(255)));
        end else if (kind >= 75) begin
          cut = $urandom_range(1, text.size());
          while (text.size() > cut) void'(text.pop_back());
        end
        send_sentence(text);
      end
    end
    in_valid <= 1'b0;
    row_typed <= 1'b0;

    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== nmea_rmc_position_parser.f =====
src/nrmc_pkg.sv
src/nrmc_parser.sv
src/nrmc_coord.sv
src/nmea_rmc_position_parser.sv
tb/testbench.sv
